// ===== rtl/core/prs_pkg.sv =====
// Shared types and constants for the power rail sequencer.
// No dependencies; compiled first.
package prs_pkg;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned CntW   = 17;
  localparam int unsigned PhaseW = 3;

  typedef enum logic [1:0] {
    REG_STEP_DELAY = 2'd0,
    REG_OFF_DELAY  = 2'd1,
    REG_ON_LOCKOUT = 2'd2,
    REG_CEC_RELOAD = 2'd3
  } reg_idx_t;

  localparam logic [CfgW-1:0] STEP_DELAY_RST = 16'd100;
  localparam logic [CfgW-1:0] OFF_DELAY_RST  = 16'd200;
  localparam logic [CfgW-1:0] ON_LOCKOUT_RST = 16'd100;

  // extra ticks on the first two power-up phases
  localparam logic [CntW-1:0] UP_PH0_EXTRA = 17'd10;
  localparam logic [CntW-1:0] UP_PH1_EXTRA = 17'd11;

  // pin_levels bit positions
  localparam int unsigned PIN_1V2 = 0;
  localparam int unsigned PIN_3V3 = 1;
  localparam int unsigned PIN_RST = 2;

  localparam logic [PhaseW-1:0] PH_0    = 3'd0;
  localparam logic [PhaseW-1:0] PH_1    = 3'd1;
  localparam logic [PhaseW-1:0] PH_2    = 3'd2;
  localparam logic [PhaseW-1:0] PH_3    = 3'd3;
  localparam logic [PhaseW-1:0] PH_4    = 3'd4;
  localparam logic [PhaseW-1:0] PH_DONE = 3'd6;

  typedef struct packed {
    logic            below;
    logic [CntW-1:0] count;
  } cnt_res_t;

  // one phase tick: bump the counter, wrap to zero when the limit is hit
  function automatic cnt_res_t count_step(input logic [CntW-1:0] cnt,
                                          input logic [CntW-1:0] limit);
    cnt_res_t        res;
    logic [CntW-1:0] inc;
    inc = cnt + 17'd1;
    res.below = (inc < limit);
    res.count = res.below ? inc : '0;
    return res;
  endfunction

endpackage

// ===== rtl/core/prs_ifs.sv =====
// Valid/ready channel interfaces for the power rail sequencer.
// No dependencies.
interface prs_in_if;
  logic valid;
  logic ready;
  logic auto_request;
  logic hdmi_request;
  logic ir_press;

  modport source (output valid, output auto_request, output hdmi_request,
                  output ir_press, input ready);
  modport sink   (input valid, input auto_request, input hdmi_request,
                  input ir_press, output ready);
endinterface

interface prs_out_if;
  logic       valid;
  logic       ready;
  logic       rail_1v2_pin;
  logic       rail_3v3_pin;
  logic       chip_reset_pin;
  logic       powered_on;
  logic       going_up;
  logic       going_down;
  logic [2:0] sequence_phase;
  logic       cec_reload;

  modport source (output valid, output rail_1v2_pin, output rail_3v3_pin,
                  output chip_reset_pin, output powered_on, output going_up,
                  output going_down, output sequence_phase, output cec_reload,
                  input ready);
  modport sink   (input valid, input rail_1v2_pin, input rail_3v3_pin,
                  input chip_reset_pin, input powered_on, input going_up,
                  input going_down, input sequence_phase, input cec_reload,
                  output ready);
endinterface

// ===== rtl/core/power_rail_sequencer.sv =====
// Power rail sequencer top level: request handling, up/down phase sequencing.
// Depends on prs_pkg and the channel interfaces in prs_ifs.sv.
//
//  channel | direction | beat
//  --------+-----------+-----------------------------------------------
//  in_ch   | sink      | one tick: auto_request, hdmi_request, ir_press
//  out_ch  | source    | pin levels, status flags, phase, cec_reload
//  cfg_*   | write     | step_delay, off_delay, on_lockout, cec reload
//
// One beat per cycle unless out_ch stalls: the whole tick is evaluated
// combinationally from the state registers and the input beat, then lands
// in the output register, valid in the cycle after the beat is accepted.
// in_ch.ready is high while the output register is empty or being drained,
// so a stalled output holds one result and blocks further input.
// rst_n is synchronous, active low; no clearing pass is needed.
module power_rail_sequencer (
  input  logic                      clk,
  input  logic                      rst_n,
  prs_in_if.sink                    in_ch,
  prs_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  prs_pkg::reg_idx_t         cfg_index,
  input  logic [prs_pkg::CfgW-1:0]  cfg_data
);
  import prs_pkg::*;

  logic [CfgW-1:0] step_delay_r, off_delay_r, on_lockout_r;

  logic              on_flag_r, up_en_r, down_en_r, auto_pend_r;
  logic [CfgW-1:0]   off_wait_r, on_wait_r;
  logic [PhaseW-1:0] phase_r;
  logic [CntW-1:0]   pcnt_r;
  logic [2:0]        pins_r;

  logic              on_flag_nxt, up_en_nxt, down_en_nxt, auto_pend_nxt;
  logic [CfgW-1:0]   off_wait_nxt, on_wait_nxt;
  logic [PhaseW-1:0] phase_nxt;
  logic [CntW-1:0]   pcnt_nxt;
  logic [2:0]        pins_nxt;
  logic              reload_nxt;

  logic out_valid_r;
  logic accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // configuration; the CEC reload value has no consumer inside the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_delay_r <= STEP_DELAY_RST;
      off_delay_r  <= OFF_DELAY_RST;
      on_lockout_r <= ON_LOCKOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_DELAY: step_delay_r <= cfg_data;
        REG_OFF_DELAY:  off_delay_r  <= cfg_data;
        REG_ON_LOCKOUT: on_lockout_r <= cfg_data;
        REG_CEC_RELOAD: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [CntW-1:0] d;
    cnt_res_t        cr;
    logic            start_up;

    d             = {1'b0, step_delay_r};
    on_flag_nxt   = on_flag_r;
    up_en_nxt     = up_en_r;
    down_en_nxt   = down_en_r;
    auto_pend_nxt = auto_pend_r;
    off_wait_nxt  = off_wait_r;
    on_wait_nxt   = on_wait_r;
    phase_nxt     = phase_r;
    pcnt_nxt      = pcnt_r;
    pins_nxt      = pins_r;
    reload_nxt    = 1'b0;
    cr            = '0;

    if (in_ch.auto_request && auto_pend_r) begin
      up_en_nxt     = 1'b1;
      auto_pend_nxt = 1'b0;
    end

    // on_flag and off_wait are not touched before both requests are judged
    start_up = (off_wait_r == '0) && !on_flag_r &&
               (in_ch.hdmi_request || in_ch.ir_press);
    if (start_up) begin
      on_wait_nxt = on_lockout_r;
      up_en_nxt   = 1'b1;
      down_en_nxt = 1'b0;
      phase_nxt   = PH_0;
      pcnt_nxt    = '0;
    end
    if (in_ch.ir_press && on_flag_r && on_wait_r == '0) begin
      off_wait_nxt = off_delay_r;
      up_en_nxt    = 1'b0;
      down_en_nxt  = 1'b1;
      phase_nxt    = PH_0;
      pcnt_nxt     = '0;
    end

    if (on_wait_nxt != '0) on_wait_nxt = on_wait_nxt - 16'd1;

    // up step
    if (up_en_nxt) begin
      on_flag_nxt = 1'b1;
      unique case (phase_nxt)
        PH_0: begin
          cr = count_step(pcnt_nxt, d + UP_PH0_EXTRA);
          if (cr.below) begin
            pins_nxt[PIN_1V2] = 1'b1;
            pins_nxt[PIN_3V3] = 1'b1;
            pins_nxt[PIN_RST] = 1'b0;
          end else phase_nxt = PH_1;
          pcnt_nxt = cr.count;
        end
        PH_1: begin
          cr = count_step(pcnt_nxt, d + UP_PH1_EXTRA);
          if (cr.below) pins_nxt[PIN_3V3] = 1'b0;
          else          phase_nxt = PH_2;
          pcnt_nxt = cr.count;
        end
        PH_2: begin
          cr = count_step(pcnt_nxt, d);
          if (cr.below) pins_nxt[PIN_RST] = 1'b1;
          else          phase_nxt = PH_3;
          pcnt_nxt = cr.count;
        end
        PH_3: begin
          cr = count_step(pcnt_nxt, d);
          if (cr.below) pins_nxt[PIN_RST] = 1'b0;
          else          phase_nxt = PH_4;
          pcnt_nxt = cr.count;
        end
        PH_4: begin
          cr = count_step(pcnt_nxt, d);
          if (cr.below) pins_nxt[PIN_RST] = 1'b1;
          else          phase_nxt = PH_DONE;
          pcnt_nxt = cr.count;
        end
        default: ;
      endcase
    end

    // down step, sees what the up step left
    if (down_en_nxt) begin
      if (off_wait_nxt != '0) begin
        off_wait_nxt = off_wait_nxt - 16'd1;
      end else begin
        unique case (phase_nxt)
          PH_0: begin
            cr = count_step(pcnt_nxt, d);
            if (cr.below) begin
              pins_nxt[PIN_3V3] = 1'b1;
              pins_nxt[PIN_RST] = 1'b0;
            end else phase_nxt = PH_1;
            pcnt_nxt = cr.count;
          end
          PH_1: begin
            pins_nxt[PIN_1V2] = 1'b0;
            phase_nxt         = PH_2;
          end
          PH_2: begin
            phase_nxt   = PH_3;
            down_en_nxt = 1'b0;
            on_flag_nxt = 1'b0;
            reload_nxt  = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_flag_r   <= 1'b0;
      up_en_r     <= 1'b0;
      down_en_r   <= 1'b0;
      auto_pend_r <= 1'b1;
      off_wait_r  <= '0;
      on_wait_r   <= '0;
      phase_r     <= PH_0;
      pcnt_r      <= '0;
      pins_r      <= '0;
    end else if (accept) begin
      on_flag_r   <= on_flag_nxt;
      up_en_r     <= up_en_nxt;
      down_en_r   <= down_en_nxt;
      auto_pend_r <= auto_pend_nxt;
      off_wait_r  <= off_wait_nxt;
      on_wait_r   <= on_wait_nxt;
      phase_r     <= phase_nxt;
      pcnt_r      <= pcnt_nxt;
      pins_r      <= pins_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.rail_1v2_pin   <= pins_nxt[PIN_1V2];
      out_ch.rail_3v3_pin   <= pins_nxt[PIN_3V3];
      out_ch.chip_reset_pin <= pins_nxt[PIN_RST];
      out_ch.powered_on     <= on_flag_nxt;
      out_ch.going_up       <= up_en_nxt;
      out_ch.going_down     <= down_en_nxt;
      out_ch.sequence_phase <= phase_nxt;
      out_ch.cec_reload     <= reload_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule
